/* sv/assert_macros.svh */
// Assertion macros shared by the RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define SSCNT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while in reset.
`define SSCNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define SSCNT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SSCNT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/sscnt_pkg.sv */
// Shared constants and types for the Sturm sequence negative-pivot counter.
`timescale 1ns / 1ps
`default_nettype none

package sscnt_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int MAX_ORDER_DEF  = 1024;

  // Status returned by the serial square-and-divide unit.
  typedef struct packed {
    logic done;
    logic sat;
  } sscnt_div_stat_t;

endpackage

`default_nettype wire

/* sv/sscnt_sqdiv.sv */
// Serial unit: e*e by radix-4 shift-add, then restoring division by |pivot|, saturated.
`timescale 1ns / 1ps
`default_nettype none

module sscnt_sqdiv
  import sscnt_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [DATA_WIDTH-1:0]        ae,
  input  wire logic [DATA_WIDTH-1:0]        ap,
  input  wire logic                         p_neg,
  output logic signed [DATA_WIDTH-1:0]      quot,
  output sscnt_div_stat_t                   stat
);

  localparam int MSTEPS = (DATA_WIDTH + 1) / 2;
  localparam int MW     = 2 * MSTEPS;
  localparam int AW     = DATA_WIDTH + MW;
  localparam int CNT_W  = $clog2(DATA_WIDTH);

  localparam logic [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_MUL  = 5'b00010,
    D_CHK  = 5'b00100,
    D_DIV  = 5'b01000,
    D_FIN  = 5'b10000
  } sqdiv_state_t;

  sqdiv_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      done_r;
  logic [DATA_WIDTH-1:0]     ae_r;
  logic [DATA_WIDTH-1:0]     ap_r;
  logic                      neg_r;
  logic [AW-1:0]             acc_r;
  logic [DATA_WIDTH-1:0]     rem_r;
  logic [DATA_WIDTH-1:0]     qsh_r;
  logic                      ovf_r;
  logic [DATA_WIDTH-1:0]     quot_r;
  logic                      sat_r;

  logic [1:0]                digit;
  logic [DATA_WIDTH+1:0]     mpart;
  logic [DATA_WIDTH+1:0]     msum;
  logic [AW-1:0]             acc_step;
  logic [DATA_WIDTH-1:0]     ee_hi;
  logic                      ovf_chk;
  logic [DATA_WIDTH:0]       dtrial;
  logic [DATA_WIDTH:0]       ddiff;
  logic                      dge;
  logic [DATA_WIDTH-1:0]     rem_step;
  logic                      top_bit;
  logic                      rest_nz;
  logic                      fin_sat;
  logic [DATA_WIDTH-1:0]     fin_val;

  // Radix-4 multiplier digit sits in the low end of the accumulator.
  assign digit    = acc_r[1:0];
  assign mpart    = ({2'b00, ae_r} & {(DATA_WIDTH+2){digit[0]}})
                  + ({1'b0, ae_r, 1'b0} & {(DATA_WIDTH+2){digit[1]}});
  assign msum     = {2'b00, acc_r[AW-1:MW]} + mpart;
  assign acc_step = {msum, acc_r[MW-1:2]};

  assign ee_hi    = acc_r[2*DATA_WIDTH-1:DATA_WIDTH];
  // High half at or above the divisor: quotient needs more than DATA_WIDTH bits.
  assign ovf_chk  = (ee_hi >= ap_r);

  assign dtrial   = {rem_r, qsh_r[DATA_WIDTH-1]};
  assign ddiff    = dtrial - {1'b0, ap_r};
  assign dge      = (dtrial >= {1'b0, ap_r});
  assign rem_step = dge ? ddiff[DATA_WIDTH-1:0] : dtrial[DATA_WIDTH-1:0];

  // A negative quotient may reach the minimum exactly without clipping.
  assign top_bit  = qsh_r[DATA_WIDTH-1];
  assign rest_nz  = |qsh_r[DATA_WIDTH-2:0];
  assign fin_sat  = ovf_r | (neg_r ? (top_bit & rest_nz) : top_bit);
  assign fin_val  = neg_r ? (fin_sat ? VAL_MIN : (~qsh_r + 1'b1))
                          : (fin_sat ? VAL_MAX : qsh_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          state_nxt = D_MUL;
          cnt_nxt   = '0;
        end
      end
      D_MUL: begin
        if (cnt_r == CNT_W'(MSTEPS - 1)) begin
          state_nxt = D_CHK;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      D_CHK: begin
        state_nxt = ovf_chk ? D_FIN : D_DIV;
        cnt_nxt   = '0;
      end
      D_DIV: begin
        if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
          state_nxt = D_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      D_FIN: begin
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= (state_r == D_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      D_IDLE: begin
        if (start) begin
          ae_r  <= ae;
          ap_r  <= ap;
          neg_r <= p_neg;
          acc_r <= {{(AW-DATA_WIDTH){1'b0}}, ae};
        end
      end
      D_MUL: begin
        acc_r <= acc_step;
      end
      D_CHK: begin
        ovf_r <= ovf_chk;
        rem_r <= ee_hi;
        qsh_r <= acc_r[DATA_WIDTH-1:0];
      end
      D_DIV: begin
        rem_r <= rem_step;
        qsh_r <= {qsh_r[DATA_WIDTH-2:0], dge};
      end
      D_FIN: begin
        quot_r <= fin_val;
        sat_r  <= fin_sat;
      end
      default: begin
      end
    endcase
  end

  assign quot      = quot_r;
  assign stat.done = done_r;
  assign stat.sat  = sat_r;

endmodule

`default_nettype wire

/* sv/sturm_sequence_negative_count.sv */
// Top level: Sturm sequence negative-pivot counter for a symmetric tridiagonal matrix.
//
// Input channel (in_valid/in_ready): one beat per matrix row, carrying the diagonal,
// the coupling to the previous row, the trial shift and a last-row flag, signed
// fixed point. The first beat after reset or after a last row opens a new pass.
// Output channel (out_valid/out_ready): one beat per pass, sent at the last row,
// with the count of negative pivots (eigenvalues below the shift) and a sticky
// flag set if any quotient or pivot saturated during the pass.
// Row handling: the first row of a pass needs no divide and goes from acceptance
// straight to the pivot step. Every later row waits on the serial unit: e*e
// formed two multiplier bits per cycle, then a restoring divide one quotient
// bit per cycle. A quotient too wide for DATA_WIDTH bits skips the divide.
// One row is in flight at a time. The result beat is registered; the next pass
// may start while it waits. If the receiver still holds off when a further result
// is ready, the block waits on that row and in_ready stays low until the old beat
// is taken.
// Reset (rst_n, synchronous, active low) drops out_valid and opens a new pass.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sturm_sequence_negative_count
  import sscnt_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int MAX_ORDER  = MAX_ORDER_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] in_diag_value,
  input  wire logic signed [DATA_WIDTH-1:0] in_coupling_value,
  input  wire logic signed [DATA_WIDTH-1:0] in_trial_shift,
  input  wire logic                         in_last_row,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [$clog2(MAX_ORDER+1)-1:0]    out_below_count,
  output logic                              out_clipped
);

  localparam int CW = $clog2(MAX_ORDER + 1);

  localparam logic [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_PIV  = 3'b100
  } top_state_t;

  top_state_t                    state_r, state_nxt;
  logic [DATA_WIDTH-1:0]         prev_pivot_r;
  logic [CW-1:0]                 cnt_r;
  logic                          mid_pass_r;
  logic                          sat_seen_r;
  logic [DATA_WIDTH:0]           dm_r;
  logic                          first_r;
  logic                          last_r;
  logic                          out_valid_r;
  logic [CW-1:0]                 out_count_r;
  logic                          out_clip_r;

  logic                          accept;
  logic                          div_start;
  logic [DATA_WIDTH-1:0]         ae;
  logic [DATA_WIDTH-1:0]         ap;
  logic                          p_neg;
  logic signed [DATA_WIDTH-1:0]  div_quot;
  sscnt_div_stat_t               div_stat;
  logic [DATA_WIDTH-1:0]         quot_use;
  logic [DATA_WIDTH+1:0]         diff;
  logic                          piv_sat;
  logic                          piv_neg;
  logic [DATA_WIDTH-1:0]         pivot;
  logic [CW-1:0]                 cnt_inc;
  logic                          out_load;
  logic                          piv_done;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign div_start = accept && mid_pass_r;

  assign ae    = in_coupling_value[DATA_WIDTH-1] ? (~in_coupling_value + 1'b1)
                                                 : in_coupling_value;
  // A zero pivot is taken as one LSB.
  assign p_neg = prev_pivot_r[DATA_WIDTH-1];
  assign ap    = p_neg ? (~prev_pivot_r + 1'b1)
               : ((prev_pivot_r == '0) ? {{(DATA_WIDTH-1){1'b0}}, 1'b1} : prev_pivot_r);

  sscnt_sqdiv #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_sqdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .ae    (ae),
    .ap    (ap),
    .p_neg (p_neg),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // Pivot = (d - mu) - quotient, exact in DATA_WIDTH+2 bits, then clamped.
  assign quot_use = first_r ? '0 : div_quot;
  assign diff     = {dm_r[DATA_WIDTH], dm_r} - {{2{quot_use[DATA_WIDTH-1]}}, quot_use};
  assign piv_sat  = (diff[DATA_WIDTH+1:DATA_WIDTH-1] != 3'b000)
                 && (diff[DATA_WIDTH+1:DATA_WIDTH-1] != 3'b111);
  assign piv_neg  = diff[DATA_WIDTH+1];
  assign pivot    = piv_sat ? (piv_neg ? VAL_MIN : VAL_MAX) : diff[DATA_WIDTH-1:0];
  assign cnt_inc  = (piv_neg && (cnt_r != {CW{1'b1}})) ? (cnt_r + 1'b1) : cnt_r;

  assign out_load = (state_r == ST_PIV) && last_r && (!out_valid_r || out_ready);
  assign piv_done = (state_r == ST_PIV) && (!last_r || !out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = mid_pass_r ? ST_BUSY : ST_PIV;
        end
      end
      ST_BUSY: begin
        if (div_stat.done) begin
          state_nxt = ST_PIV;
        end
      end
      ST_PIV: begin
        if (piv_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      prev_pivot_r <= '0;
      cnt_r        <= '0;
      mid_pass_r   <= 1'b0;
      sat_seen_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_BUSY) && div_stat.done && div_stat.sat) begin
        sat_seen_r <= 1'b1;
      end
      if (piv_done) begin
        if (last_r) begin
          prev_pivot_r <= '0;
          cnt_r        <= '0;
          mid_pass_r   <= 1'b0;
          sat_seen_r   <= 1'b0;
        end else begin
          prev_pivot_r <= pivot;
          cnt_r        <= cnt_inc;
          mid_pass_r   <= 1'b1;
          sat_seen_r   <= sat_seen_r | piv_sat;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dm_r    <= {in_diag_value[DATA_WIDTH-1], in_diag_value}
               - {in_trial_shift[DATA_WIDTH-1], in_trial_shift};
      first_r <= !mid_pass_r;
      last_r  <= in_last_row;
    end
    if (out_load) begin
      out_count_r <= cnt_inc;
      out_clip_r  <= sat_seen_r | piv_sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_below_count = out_count_r;
  assign out_clipped     = out_clip_r;

  // One row at a time: an accepted beat always drops ready for the next cycle.
  `SSCNT_ASSERT_NEXT(a_one_row_in_flight, clk, rst_n, accept, !in_ready)
  // The divider only reports completion while a row waits on it.
  `SSCNT_ASSERT_IMPLIES(a_done_when_busy, clk, rst_n, div_stat.done, state_r == ST_BUSY)
  // A fresh result beat coincides with the pass state being cleared.
  `SSCNT_ASSERT_IMPLIES(a_pass_cleared, clk, rst_n, $rose(out_valid_r),
                        (cnt_r == '0) && !mid_pass_r && !sat_seen_r)

endmodule

`default_nettype wire
